/* rtl/ctsf_pkg.sv */
// ctsf_pkg: shared types and constants for the cruise target speed block
// no dependencies; imported by the divider, controller, datapath and top level
`default_nettype none

package ctsf_pkg;

  localparam int unsigned SpeedW   = 8;
  localparam int unsigned CountW   = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivCntW  = 4;

  localparam logic [CountW-1:0]  COUNT_MAX = {CountW{1'b1}};
  localparam logic [DivCntW-1:0] DIV_STEPS = DivCntW'(CountW);

  localparam logic [CfgIdxW-1:0] REG_HOLD_RATE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED = 2'd3;

  localparam logic [SpeedW-1:0] HOLD_RATE_RST = 8'd5;
  localparam logic [SpeedW-1:0] STEP_SIZE_RST = 8'd1;
  localparam logic [SpeedW-1:0] MAX_SPEED_RST = 8'd90;
  localparam logic [SpeedW-1:0] MIN_SPEED_RST = 8'd20;

  typedef enum logic [1:0] {
    HM_NONE   = 2'd0,
    HM_STEADY = 2'd1,
    HM_ACCEL  = 2'd2,
    HM_COAST  = 2'd3
  } hold_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_UPD  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic update;
  } ctsf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctsf_sts_t;

endpackage

`default_nettype wire

/* rtl/ctsf_div.sv */
// ctsf_div: restoring divider, one quotient bit per cycle
// computes (10 * step_size) / hold_rate; uses ctsf_pkg
`default_nettype none

module ctsf_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ctsf_pkg::SpeedW-1:0]   step_size,
  input  wire logic [ctsf_pkg::SpeedW-1:0]   hold_rate,
  output logic                               done,
  output logic [ctsf_pkg::CountW-1:0]        quotient
);
  import ctsf_pkg::*;

  logic [CountW-1:0]  qn_r, qn_nxt;
  logic [SpeedW-1:0]  rem_r, rem_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [SpeedW:0]    rem_sh;
  logic [SpeedW:0]    rem_sub;
  logic [CountW-1:0]  dividend;

  assign dividend = ({1'b0, step_size, 3'b000} + {3'b000, step_size, 1'b0});
  assign rem_sh   = {rem_r, qn_r[CountW-1]};
  assign rem_sub  = rem_sh - {1'b0, hold_rate};

  always_comb begin
    qn_nxt  = qn_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      qn_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = DIV_STEPS;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (rem_sh >= {1'b0, hold_rate}) begin
        rem_nxt = rem_sub[SpeedW-1:0];
        qn_nxt  = {qn_r[CountW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[SpeedW-1:0];
        qn_nxt  = {qn_r[CountW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = qn_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == DIV_STEPS)
    else $error("divider start not taken");

endmodule

`default_nettype wire

/* rtl/ctsf_ctrl.sv */
// ctsf_ctrl: sequencing state machine for one tick
// drives datapath commands from its status; uses ctsf_pkg
`default_nettype none

module ctsf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctsf_pkg::ctsf_sts_t sts,
  output ctsf_pkg::ctsf_cmd_t      cmd
);
  import ctsf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = ST_UPD;
      ST_UPD:  if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.update = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV: ;
      ST_UPD:  cmd.update = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_DIV)
    else $error("transfer did not start a division");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !sts.div_done) |=> state_r == ST_DIV)
    else $error("left division early");

  a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (state_r == ST_IDLE && !in_stall))
    else $error("no return to idle after update");

endmodule

`default_nettype wire

/* rtl/ctsf_dp.sv */
// ctsf_dp: config registers, mode state, target speed and output register
// instantiates ctsf_div; uses ctsf_pkg
`default_nettype none

module ctsf_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ctsf_pkg::ctsf_cmd_t           cmd,
  output ctsf_pkg::ctsf_sts_t                sts,
  input  wire logic                          cfg_we,
  input  wire logic [ctsf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ctsf_pkg::SpeedW-1:0]   cfg_data,
  input  wire logic                          in_cruise_on,
  input  wire logic                          in_brake,
  input  wire logic [ctsf_pkg::SpeedW-1:0]   in_vehicle_speed,
  input  wire logic                          in_coast_set_switch,
  input  wire logic                          in_accel_resume_switch,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_engaged,
  output logic [ctsf_pkg::SpeedW-1:0]        out_target_speed
);
  import ctsf_pkg::*;

  logic [SpeedW-1:0] hold_rate_r, step_size_r, max_speed_r, min_speed_r;

  logic              on_r, brake_r, coast_r, accel_r;
  logic [SpeedW-1:0] speed_r;

  logic              activated_r, activated_nxt;
  logic              cruise_mode_r, cruise_mode_nxt;
  logic              engage_mode_r, engage_mode_nxt;
  hold_mode_t        hold_mode_r, hold_mode_nxt;
  logic [CountW-1:0] hold_count_r, hold_count_nxt;
  logic [SpeedW-1:0] target_r, target_nxt;
  logic              accel_prev_r, coast_prev_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_engaged_r, engaged_nxt;
  logic [SpeedW-1:0] out_target_r;

  logic              div_done;
  logic [CountW-1:0] threshold;
  logic              accel_rise, coast_rise, speed_ok, fire;
  logic [CountW-1:0] count_inc;
  logic [SpeedW-1:0] target_up, target_dn;

  ctsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.load),
    .step_size (step_size_r),
    .hold_rate (hold_rate_r),
    .done      (div_done),
    .quotient  (threshold)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_rate_r <= HOLD_RATE_RST;
      step_size_r <= STEP_SIZE_RST;
      max_speed_r <= MAX_SPEED_RST;
      min_speed_r <= MIN_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_RATE: hold_rate_r <= cfg_data;
        REG_STEP_SIZE: step_size_r <= cfg_data;
        REG_MAX_SPEED: max_speed_r <= cfg_data;
        REG_MIN_SPEED: min_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      on_r    <= in_cruise_on;
      brake_r <= in_brake;
      speed_r <= in_vehicle_speed;
      coast_r <= in_coast_set_switch;
      accel_r <= in_accel_resume_switch;
    end
  end

  assign accel_rise = accel_r & ~accel_prev_r;
  assign coast_rise = coast_r & ~coast_prev_r;
  assign speed_ok   = (speed_r <= max_speed_r) && (speed_r >= min_speed_r);
  assign count_inc  = (hold_count_r != COUNT_MAX) ? hold_count_r + 1'b1 : hold_count_r;
  assign fire       = (hold_rate_r != '0) && (count_inc >= threshold);
  assign target_up  = target_r + step_size_r;
  assign target_dn  = target_r - step_size_r;

  always_comb begin
    activated_nxt   = activated_r;
    cruise_mode_nxt = cruise_mode_r;
    engage_mode_nxt = engage_mode_r;
    hold_mode_nxt   = hold_mode_r;
    hold_count_nxt  = hold_count_r;
    target_nxt      = target_r;
    engaged_nxt     = 1'b0;
    if (!activated_r) begin
      activated_nxt   = 1'b1;
      cruise_mode_nxt = 1'b0;
      target_nxt      = '0;
    end else if (cruise_mode_r) begin
      if (!on_r) begin
        cruise_mode_nxt = 1'b0;
        engage_mode_nxt = 1'b0;
        hold_mode_nxt   = HM_NONE;
        target_nxt      = '0;
      end else if (engage_mode_r) begin
        engaged_nxt = 1'b1;
        if (brake_r || !speed_ok) begin
          engage_mode_nxt = 1'b0;
          hold_mode_nxt   = HM_NONE;
          engaged_nxt     = 1'b0;
        end else if (hold_mode_r == HM_ACCEL || hold_mode_r == HM_COAST) begin
          hold_count_nxt = count_inc;
          if (fire) begin
            hold_count_nxt = '0;
            target_nxt     = (hold_mode_r == HM_ACCEL) ? target_up : target_dn;
          end else if (hold_mode_r == HM_ACCEL) begin
            if (!accel_r || target_r >= max_speed_r) hold_mode_nxt = HM_STEADY;
          end else begin
            if (!coast_r || target_r <= min_speed_r) hold_mode_nxt = HM_STEADY;
          end
        end else begin
          hold_count_nxt = '0;
          if (accel_rise && target_r < max_speed_r) begin
            hold_mode_nxt = HM_ACCEL;
            target_nxt    = target_up;
          end else if (coast_rise && target_r > min_speed_r) begin
            hold_mode_nxt = HM_COAST;
            target_nxt    = target_dn;
          end else if (coast_rise) begin
            hold_mode_nxt = HM_STEADY;
            target_nxt    = speed_r;
          end
        end
      end else begin
        if (!brake_r && speed_ok) begin
          if (accel_rise && target_r != '0) begin
            engage_mode_nxt = 1'b1;
            hold_mode_nxt   = HM_STEADY;
            engaged_nxt     = 1'b1;
          end else if (coast_rise) begin
            engage_mode_nxt = 1'b1;
            hold_mode_nxt   = HM_STEADY;
            engaged_nxt     = 1'b1;
            target_nxt      = speed_r;
          end
        end
      end
    end else begin
      if (on_r) begin
        cruise_mode_nxt = 1'b1;
        engage_mode_nxt = 1'b0;
        hold_mode_nxt   = HM_NONE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      activated_r   <= 1'b0;
      cruise_mode_r <= 1'b0;
      engage_mode_r <= 1'b0;
      hold_mode_r   <= HM_NONE;
      hold_count_r  <= '0;
      target_r      <= '0;
      accel_prev_r  <= 1'b0;
      coast_prev_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.update) begin
        activated_r   <= activated_nxt;
        cruise_mode_r <= cruise_mode_nxt;
        engage_mode_r <= engage_mode_nxt;
        hold_mode_r   <= hold_mode_nxt;
        hold_count_r  <= hold_count_nxt;
        target_r      <= target_nxt;
        accel_prev_r  <= accel_r;
        coast_prev_r  <= coast_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_engaged_r <= engaged_nxt;
      out_target_r  <= target_nxt;
    end
  end

  assign sts.div_done     = div_done;
  assign sts.out_free     = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_engaged      = out_engaged_r;
  assign out_target_speed = out_target_r;

  a_upd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  a_standby_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !engage_mode_r |-> hold_mode_r == HM_NONE)
    else $error("hold mode set outside on mode");

endmodule

`default_nettype wire

/* rtl/cruise_target_speed_fsm_unit.sv */
// cruise_target_speed_fsm_unit: top level of the cruise target speed block
// instantiates ctsf_ctrl and ctsf_dp; uses ctsf_pkg
//
//   channel  handshake            payload
//   in       in_valid / in_stall  cruise_on, brake, vehicle_speed, coast_set, accel_resume
//   out      out_valid/out_stall  engaged, target_speed
//   cfg      cfg_valid/cfg_ready  cfg_index (2 bits), cfg_data (8 bits)
//
// one tick passes through the transfer in idle, the divide state (twelve quotient
// bits, then done is seen) and the update
// the result register lets the next tick be taken while a result waits; the
// update of that tick holds until the result register is free
// synchronous active-low reset; config writes are always ready
`default_nettype none

module cruise_target_speed_fsm_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cruise_on,
  input  wire logic                          in_brake,
  input  wire logic [ctsf_pkg::SpeedW-1:0]   in_vehicle_speed,
  input  wire logic                          in_coast_set_switch,
  input  wire logic                          in_accel_resume_switch,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_engaged,
  output logic [ctsf_pkg::SpeedW-1:0]        out_target_speed,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ctsf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ctsf_pkg::SpeedW-1:0]   cfg_data
);
  import ctsf_pkg::*;

  ctsf_cmd_t cmd;
  ctsf_sts_t sts;

  assign cfg_ready = 1'b1;

  ctsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctsf_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_valid & cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_cruise_on           (in_cruise_on),
    .in_brake               (in_brake),
    .in_vehicle_speed       (in_vehicle_speed),
    .in_coast_set_switch    (in_coast_set_switch),
    .in_accel_resume_switch (in_accel_resume_switch),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_engaged            (out_engaged),
    .out_target_speed       (out_target_speed)
  );

endmodule

`default_nettype wire
